FILE: rtl/core/orientation_order_parameters_macros.svh
// assertion macros for the orientation order parameter block
`ifndef ORIENTATION_ORDER_PARAMETERS_MACROS_SVH
`define ORIENTATION_ORDER_PARAMETERS_MACROS_SVH

// same-cycle implication, disabled during reset
`define OOP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define OOP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/oop_pkg.sv
// types and constants shared by the orientation order parameter block
package oop_pkg;

	localparam int unsigned WEIGHT_W = 18;
	localparam int unsigned DSUM_W   = 24;
	localparam int unsigned MOM_W    = 40;
	localparam int unsigned TEN_W    = 44;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [5:0]        angle_index;
		logic signed [15:0] cos_value;
		logic signed [15:0] sin_value;
		logic [15:0]       density;
		logic              last_sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] concentration;
		logic [15:0] polar_order;
		logic [15:0] nematic_order;
		logic        zero_density;
	} out_item_t;

	typedef struct packed {
		logic [DSUM_W-1:0]        density_sum;
		logic signed [MOM_W-1:0]  moment_x;
		logic signed [MOM_W-1:0]  moment_y;
		logic signed [TEN_W-1:0]  tensor_xx;
		logic signed [TEN_W-1:0]  tensor_xy;
		logic signed [TEN_W-1:0]  tensor_yy;
	} sums_t;

	typedef struct packed {
		logic        done;
		logic [15:0] polar;
		logic [15:0] nematic;
	} post_status_t;

endpackage

FILE: rtl/core/oop_post.sv
// serial square, square root and divide unit for the order magnitudes
module oop_post import oop_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  sums_t        sums,
	output post_status_t status
);

	localparam int unsigned OW = 46;
	localparam int unsigned AW = 2 * OW;
	localparam int unsigned NW = 48;
	localparam int unsigned DW = DSUM_W + 1;

	typedef enum logic [5:0] {
		P_IDLE = 6'b000001,
		P_SQ   = 6'b000010,
		P_ROOT = 6'b000100,
		P_DSET = 6'b001000,
		P_DIV  = 6'b010000,
		P_DONE = 6'b100000
	} phase_t;

	phase_t             phase_q;
	logic               job_q;
	logic               sq_sel_q;
	logic [5:0]         cnt_q;
	logic [AW-1:0]      acc_q;
	logic [AW-1:0]      mcand_q;
	logic [OW-1:0]      mplier_q;
	logic [NW-1:0]      rem_q;
	logic [OW-1:0]      root_q;
	logic [NW-1:0]      dnum_q;
	logic [DW:0]        drem_q;
	logic               neg_q;
	logic [15:0]        polar_q;
	logic [15:0]        nematic_q;

	logic [DW-1:0]      divisor;
	logic [NW+1:0]      rem_n;
	logic [NW+1:0]      trial;
	logic [DW:0]        dr_n;
	logic signed [OW-1:0] op_a;
	logic signed [OW-1:0] op_b;
	logic signed [NW-1:0] num;
	logic [15:0]        quot_sat;

	function automatic logic [OW-1:0] mag(input logic signed [OW-1:0] x);
		mag = x[OW-1] ? OW'(-x) : OW'(x);
	endfunction

	assign divisor = {sums.density_sum, 1'b0};
	assign rem_n   = {rem_q, acc_q[AW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign dr_n    = {drem_q[DW-1:0], dnum_q[NW-1]};
	assign num     = NW'(signed'(sums.tensor_xx + (TEN_W+1)'(sums.tensor_yy)))
		+ signed'(NW'(root_q));
	assign quot_sat = (|dnum_q[NW-1:16]) ? 16'hFFFF : dnum_q[15:0];

	// operands of the second square pair: tensor_xx - tensor_yy and twice tensor_xy
	always_comb begin
		op_a = OW'(sums.tensor_xx) - OW'(sums.tensor_yy);
		op_b = OW'(sums.tensor_xy) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			unique case (phase_q)
				P_IDLE:  if (start) phase_q <= P_SQ;
				P_SQ:    if (cnt_q == 6'(OW-1) && sq_sel_q) phase_q <= P_ROOT;
				P_ROOT:  if (cnt_q == 6'(OW-1)) phase_q <= P_DSET;
				P_DSET:  phase_q <= P_DIV;
				P_DIV:   if (cnt_q == 6'(NW-1)) phase_q <= job_q ? P_DONE : P_SQ;
				P_DONE:  phase_q <= P_IDLE;
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				job_q    <= 1'b0;
				sq_sel_q <= 1'b0;
				cnt_q    <= '0;
				acc_q    <= '0;
				mcand_q  <= AW'(mag(OW'(sums.moment_x)));
				mplier_q <= mag(OW'(sums.moment_x));
			end
			P_SQ: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + 6'd1;
				if (cnt_q == 6'(OW-1)) begin
					cnt_q <= '0;
					if (!sq_sel_q) begin
						sq_sel_q <= 1'b1;
						mcand_q  <= AW'(job_q ? mag(op_b) : mag(OW'(sums.moment_y)));
						mplier_q <= job_q ? mag(op_b) : mag(OW'(sums.moment_y));
					end else begin
						rem_q  <= '0;
						root_q <= '0;
					end
				end
			end
			P_ROOT: begin
				// one result bit per cycle
				if (rem_n >= trial) begin
					rem_q  <= NW'(rem_n - trial);
					root_q <= {root_q[OW-2:0], 1'b1};
				end else begin
					rem_q  <= NW'(rem_n);
					root_q <= {root_q[OW-2:0], 1'b0};
				end
				acc_q <= acc_q << 2;
				cnt_q <= (cnt_q == 6'(OW-1)) ? 6'd0 : cnt_q + 6'd1;
			end
			P_DSET: begin
				drem_q <= '0;
				if (job_q) begin
					dnum_q <= NW'(num);
					neg_q  <= num[NW-1];
				end else begin
					dnum_q <= NW'(root_q);
					neg_q  <= 1'b0;
				end
			end
			P_DIV: begin
				if (dr_n >= {1'b0, divisor}) begin
					drem_q <= dr_n - {1'b0, divisor};
					dnum_q <= {dnum_q[NW-2:0], 1'b1};
				end else begin
					drem_q <= dr_n;
					dnum_q <= {dnum_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NW-1)) begin
					cnt_q    <= '0;
					job_q    <= 1'b1;
					sq_sel_q <= 1'b0;
					acc_q    <= '0;
					mcand_q  <= AW'(mag(op_a));
					mplier_q <= mag(op_a);
				end
			end
			default: ;
		endcase
	end

	// results taken after the last quotient bit lands
	always_ff @(posedge clk) begin
		if (phase_q == P_DSET && job_q) polar_q <= polar_q;
		if (phase_q == P_SQ && job_q && cnt_q == 6'd0 && !sq_sel_q) polar_q <= quot_sat;
		if (phase_q == P_DONE) nematic_q <= neg_q ? 16'd0 : quot_sat;
	end

	assign status.done    = (phase_q == P_DONE);
	assign status.polar   = polar_q;
	assign status.nematic = nematic_q;

endmodule

FILE: rtl/core/orientation_order_parameters.sv
// orientation order parameters: angle table, per-cell sums and result register
//
// Requests arrive on item_valid/item_ready. A load request (operation 0)
// writes one cosine/sine entry of the angle table. A sample request reads
// the table and folds the density into the cell sums through the read,
// multiply and add states before the next request is taken.
// A sample with last_sample set then runs the serial post unit: two 46-step
// shift-add squares, a 46-step square root and a 48-step divide, twice,
// on the one-bit-per-cycle post datapath. The result waits in an output
// register on result_valid/result_ready; the next request is taken while
// it waits, and a second closed cell holds in the block until the register
// is free. cfg_we writes the weight register. Reset clears the sums and the
// result register and sets the weight to 6434; the angle table is undefined
// until loaded.
module orientation_order_parameters import oop_pkg::*; #(
	parameter int unsigned ANGLES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  in_item_t            item,
	output logic                result_valid,
	input  logic                result_ready,
	output out_item_t           result,
	input  logic                cfg_we,
	input  logic [WEIGHT_W-1:0] cfg_wdata
);

	`include "orientation_order_parameters_macros.svh"

	localparam int unsigned TW = (ANGLES > 1) ? $clog2(ANGLES) : 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD    = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_ADD   = 7'b0001000,
		S_START = 7'b0010000,
		S_WAIT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [31:0]          tbl [ANGLES];
	logic [31:0]          rd_q;
	logic [TW-1:0]        addr;
	logic                 idx_ok;
	logic                 accept;
	logic                 idx_ok_q;
	logic [15:0]          rho_q;
	logic                 last_q;
	logic signed [15:0]   c_q;
	logic signed [15:0]   s_q;
	logic signed [31:0]   cc_q;
	logic signed [31:0]   ss_q;
	logic signed [31:0]   cs_q;
	logic signed [33:0]   px_q;
	logic signed [33:0]   py_q;
	logic signed [33:0]   pxx_q;
	logic signed [33:0]   pxy_q;
	logic signed [33:0]   pyy_q;
	sums_t                sums_q;
	logic [41:0]          prod_q;
	logic                 load_out;
	post_status_t         post;
	logic signed [15:0]   c_rd;
	logic signed [15:0]   s_rd;
	logic signed [16:0]   rho_s;
	logic signed [16:0]   rcc;
	logic signed [16:0]   rss;
	logic signed [16:0]   rcs;
	logic [24:0]          ds_n;
	logic signed [40:0]   mx_n;
	logic signed [40:0]   my_n;
	logic signed [44:0]   txx_n;
	logic signed [44:0]   txy_n;
	logic signed [44:0]   tyy_n;
	logic [42:0]          conc_n;

	function automatic logic signed [16:0] rnd15(input logic signed [31:0] x);
		logic signed [32:0] t;
		t = 33'(x) + 33'sd16384;
		rnd15 = 17'(t >>> 15);
	endfunction

	function automatic logic signed [MOM_W-1:0] sat40(input logic signed [40:0] x);
		if (x[40] != x[39]) sat40 = x[40] ? {1'b1, {(MOM_W-1){1'b0}}} : {1'b0, {(MOM_W-1){1'b1}}};
		else sat40 = x[MOM_W-1:0];
	endfunction

	function automatic logic signed [TEN_W-1:0] sat44(input logic signed [44:0] x);
		if (x[44] != x[43]) sat44 = x[44] ? {1'b1, {(TEN_W-1){1'b0}}} : {1'b0, {(TEN_W-1){1'b1}}};
		else sat44 = x[TEN_W-1:0];
	endfunction

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign addr       = TW'(item.angle_index);
	assign idx_ok     = 32'(item.angle_index) < ANGLES;
	assign load_out   = (state_q == S_OUT) && (!result_valid || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) weight_q <= WEIGHT_W'(6434);
		else if (cfg_we) weight_q <= cfg_wdata;
	end

	// angle table: cosine in the upper half, sine in the lower
	always_ff @(posedge clk) begin
		if (accept && item.operation == OP_LOAD && idx_ok)
			tbl[addr] <= {item.cos_value, item.sin_value};
		rd_q <= tbl[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (accept && item.operation == OP_SAMPLE) state_q <= S_RD;
				S_RD:    state_q <= S_MUL;
				S_MUL:   state_q <= S_ADD;
				S_ADD:   state_q <= last_q ? S_START : S_IDLE;
				S_START: state_q <= S_WAIT;
				S_WAIT:  if (post.done) state_q <= S_OUT;
				S_OUT:   if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign c_rd  = idx_ok_q ? signed'(rd_q[31:16]) : 16'sd0;
	assign s_rd  = idx_ok_q ? signed'(rd_q[15:0]) : 16'sd0;
	assign rho_s = signed'({1'b0, rho_q});
	assign rcc   = rnd15(cc_q) - 17'sd16384;
	assign rss   = rnd15(ss_q) - 17'sd16384;
	assign rcs   = rnd15(cs_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			rho_q    <= item.density;
			last_q   <= item.last_sample;
			idx_ok_q <= idx_ok;
		end
		if (state_q == S_RD) begin
			c_q  <= c_rd;
			s_q  <= s_rd;
			cc_q <= c_rd * c_rd;
			ss_q <= s_rd * s_rd;
			cs_q <= c_rd * s_rd;
		end
		if (state_q == S_MUL) begin
			px_q  <= rho_s * c_q;
			py_q  <= rho_s * s_q;
			pxx_q <= rho_s * rcc;
			pxy_q <= rho_s * rcs;
			pyy_q <= rho_s * rss;
		end
		if (state_q == S_START) prod_q <= 42'(weight_q) * 42'(sums_q.density_sum);
	end

	assign ds_n  = {1'b0, sums_q.density_sum} + 25'(rho_q);
	assign mx_n  = 41'(sums_q.moment_x) + 41'(px_q);
	assign my_n  = 41'(sums_q.moment_y) + 41'(py_q);
	assign txx_n = 45'(sums_q.tensor_xx) + 45'(pxx_q);
	assign txy_n = 45'(sums_q.tensor_xy) + 45'(pxy_q);
	assign tyy_n = 45'(sums_q.tensor_yy) + 45'(pyy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (state_q == S_ADD) begin
			sums_q.density_sum <= ds_n[24] ? {DSUM_W{1'b1}} : ds_n[DSUM_W-1:0];
			sums_q.moment_x    <= sat40(mx_n);
			sums_q.moment_y    <= sat40(my_n);
			sums_q.tensor_xx   <= sat44(txx_n);
			sums_q.tensor_xy   <= sat44(txy_n);
			sums_q.tensor_yy   <= sat44(tyy_n);
		end else if (load_out) begin
			sums_q <= '0;
		end
	end

	oop_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_START),
		.sums   (sums_q),
		.status (post)
	);

	assign conc_n = 43'(prod_q) + 43'd2048;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (result_valid && result_ready) result_valid <= 1'b0;
			if (load_out) begin
				result_valid                <= 1'b1;
				result.concentration        <= 32'(conc_n >> 12);
				result.zero_density         <= (prod_q == '0);
				result.polar_order          <= (prod_q == '0) ? 16'd0 : post.polar;
				result.nematic_order        <= (prod_q == '0) ? 16'd0 : post.nematic;
			end
		end
	end

	`OOP_ASSERT_NOW(a_out_free, load_out, !result_valid || result_ready, "result overwritten")
	`OOP_ASSERT_NOW(a_done_wait, post.done, state_q == S_WAIT, "post finished outside wait")
	`OOP_ASSERT_NOW(a_zero_orders, result_valid && result.zero_density,
		result.polar_order == 16'd0 && result.nematic_order == 16'd0, "zero cell with order")

endmodule

FILE: dv/orientation_order_parameters_tb.sv
// testbench for the orientation order parameter block: directed and random requests checked against a predictor
module orientation_order_parameters_tb;
	import oop_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 4000000;
	localparam int unsigned SETTLE_CYCLES = 800;
	localparam int unsigned RANDOM_ITEMS = 1100;

	class cell_scoreboard;
		longint unsigned weight;
		longint cos_tab[64];
		longint sin_tab[64];
		longint dsum, mom_x, mom_y, ten_xx, ten_xy, ten_yy;
		out_item_t cell_results[$];
		int errors;

		function new();
			weight = 6434;
			errors = 0;
			clear();
		endfunction

		function void clear();
			dsum = 0;
			mom_x = 0;
			mom_y = 0;
			ten_xx = 0;
			ten_xy = 0;
			ten_yy = 0;
		endfunction

		function longint sat_add(longint acc, longint add, int bits);
			longint hi, lo, r;
			hi = (64'sd1 <<< (bits - 1)) - 1;
			lo = -hi - 1;
			r = acc + add;
			if (r > hi) r = hi;
			if (r < lo) r = lo;
			return r;
		endfunction

		function logic [127:0] sq(longint x);
			logic [63:0] m;
			m = (x < 0) ? -x : x;
			return {64'b0, m} * {64'b0, m};
		endfunction

		// fold one accepted request, queue the cell result when it closes
		function void note(in_item_t x);
			longint c, s, rho, cc, ss, cs, prod, d, tr, tp, tn, v;
			logic [127:0] m2, disc;
			longint unsigned conc;
			logic [15:0] polar, nematic;
			out_item_t r;
			if (x.operation == OP_LOAD) begin
				cos_tab[x.angle_index] = longint'($signed(x.cos_value));
				sin_tab[x.angle_index] = longint'($signed(x.sin_value));
				return;
			end
			rho = longint'(x.density);
			c = cos_tab[x.angle_index];
			s = sin_tab[x.angle_index];
			cc = (c * c + 16384) >>> 15;
			ss = (s * s + 16384) >>> 15;
			cs = (c * s + 16384) >>> 15;
			dsum = dsum + rho;
			if (dsum > 64'hFFFFFF) dsum = 64'hFFFFFF;
			mom_x = sat_add(mom_x, rho * c, MOM_W);
			mom_y = sat_add(mom_y, rho * s, MOM_W);
			ten_xx = sat_add(ten_xx, rho * (cc - 16384), TEN_W);
			ten_xy = sat_add(ten_xy, rho * cs, TEN_W);
			ten_yy = sat_add(ten_yy, rho * (ss - 16384), TEN_W);
			if (!x.last_sample) return;
			prod = longint'(weight) * dsum;
			conc = (prod + 2048) >> 12;
			if (conc > 64'hFFFFFFFF) conc = 64'hFFFFFFFF;
			polar = '0;
			nematic = '0;
			r.zero_density = (prod == 0);
			if (prod != 0) begin
				d = 2 * dsum;
				m2 = sq(mom_x) + sq(mom_y);
				tr = ten_xx + ten_yy;
				disc = sq(ten_xx - ten_yy) + sq(2 * ten_xy);
				for (int b = 15; b >= 0; b--) begin
					tp = longint'(polar | (16'd1 << b));
					if (sq(d * tp) <= m2) polar = tp[15:0];
					tn = longint'(nematic | (16'd1 << b));
					v = d * tn - tr;
					if (v <= 0 || sq(v) <= disc) nematic = tn[15:0];
				end
			end
			r.concentration = conc[31:0];
			r.polar_order = polar;
			r.nematic_order = nematic;
			cell_results.push_back(r);
			clear();
		endfunction

		function void check(out_item_t got);
			out_item_t want;
			if (cell_results.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			want = cell_results.pop_front();
			if (got.concentration !== want.concentration) begin
				$error("concentration: expected %0d, got %0d", want.concentration,
					got.concentration);
				errors++;
			end
			if (got.polar_order !== want.polar_order) begin
				$error("polar_order: expected %0d, got %0d", want.polar_order, got.polar_order);
				errors++;
			end
			if (got.nematic_order !== want.nematic_order) begin
				$error("nematic_order: expected %0d, got %0d", want.nematic_order,
					got.nematic_order);
				errors++;
			end
			if (got.zero_density !== want.zero_density) begin
				$error("zero_density: expected %0d, got %0d", want.zero_density,
					got.zero_density);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_item_t item;
	logic result_valid;
	logic result_ready;
	out_item_t result;
	logic cfg_we;
	logic [WEIGHT_W-1:0] cfg_wdata;

	cell_scoreboard sb;
	bit send_gaps;
	bit recv_gaps;
	bit hold_trigger;
	int unsigned hold_left;
	longint unsigned cycles;

	orientation_order_parameters dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		hold_trigger = 1'b0;
		hold_left = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("orientation_order_parameters_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) sb.note(item);
		if (arst_n && result_valid && result_ready) sb.check(result);
	end

	// receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (hold_trigger && hold_left == 0) begin
			hold_left <= 4000;
			hold_trigger <= 1'b0;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= recv_gaps ? ($urandom_range(99) >= 28) : 1'b1;
		end
	end

	task automatic send(input in_item_t x);
		while (send_gaps && $urandom_range(99) < 28) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic load(input int idx, input logic [15:0] c, input logic [15:0] s);
		in_item_t x;
		x.operation = OP_LOAD;
		x.angle_index = 6'(idx);
		x.cos_value = c;
		x.sin_value = s;
		x.density = 16'($urandom);
		x.last_sample = 1'($urandom_range(1));
		send(x);
	endtask

	task automatic sample(input int idx, input logic [15:0] rho, input bit last);
		in_item_t x;
		x.operation = OP_SAMPLE;
		x.angle_index = 6'(idx);
		x.cos_value = 16'($urandom);
		x.sin_value = 16'($urandom);
		x.density = rho;
		x.last_sample = last;
		send(x);
	endtask

	// only between phases: drain results, let the post unit settle, then write
	task automatic set_weight(input logic [WEIGHT_W-1:0] w);
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.cell_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.weight = 64'(w);
	endtask

	task automatic random_cells(input int n);
		int k;
		logic [15:0] rho;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) < 10) begin
				load(int'($urandom_range(63)), 16'($urandom), 16'($urandom));
			end else begin
				case ($urandom_range(9))
					0: rho = 16'h0000;
					1: rho = 16'hFFFF;
					2: rho = 16'($urandom_range(15));
					default: rho = 16'($urandom);
				endcase
				sample(int'($urandom_range(63)), rho, ($urandom_range(7) == 0) || k == n - 1);
			end
		end
	endtask

	initial begin
		int k;
		@(posedge arst_n);
		@(posedge clk);
		// full table so that no sample reads an entry never loaded
		load(0, 16'h7FFF, 16'h0000);
		load(1, 16'h8000, 16'h8000);
		load(2, 16'h0000, 16'h7FFF);
		load(3, 16'hFFFF, 16'h0001);
		for (k = 4; k < 64; k++) load(k, 16'($urandom), 16'($urandom));
		// directed: zero cell, extremes, single and multi-sample cells
		sample(0, 16'h0000, 1'b1);
		sample(0, 16'hFFFF, 1'b1);
		sample(1, 16'hFFFF, 1'b1);
		sample(2, 16'h0001, 1'b1);
		sample(0, 16'hFFFF, 1'b0);
		sample(2, 16'hFFFF, 1'b1);
		sample(0, 16'h1000, 1'b0);
		sample(1, 16'h1000, 1'b1);
		sample(3, 16'h8000, 1'b0);
		sample(63, 16'h7FFF, 1'b1);
		// weight zero forces the zero flag
		set_weight(18'd0);
		sample(0, 16'hFFFF, 1'b0);
		sample(5, 16'h1234, 1'b1);
		random_cells(80);
		set_weight(18'h3FFFF);
		sample(0, 16'h0001, 1'b1);
		sample(1, 16'hFFFF, 1'b1);
		random_cells(150);
		// long cells drive the sums into saturation
		for (k = 0; k < 280; k++) sample(0, 16'hFFFF, k == 279);
		for (k = 0; k < 280; k++) sample(1, 16'hFFFF, k == 279);
		set_weight(18'd1);
		sample(0, 16'h0001, 1'b1);
		sample(2, 16'h0800, 1'b1);
		random_cells(150);
		set_weight(WEIGHT_W'($urandom));
		// stretch with no idling on either side
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		random_cells(200);
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		// receiver holds off while requests keep coming
		hold_trigger <= 1'b1;
		for (k = 0; k < 60; k++)
			sample(int'($urandom_range(63)), 16'($urandom), (k % 4) == 3);
		set_weight(18'd6434);
		random_cells(RANDOM_ITEMS - 640);
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.cell_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.cell_results.size() == 0) begin
			$display("orientation_order_parameters_tb: done, clean");
		end else begin
			$display("orientation_order_parameters_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: orientation_order_parameters.f
+incdir+rtl/core
rtl/core/oop_pkg.sv
rtl/core/oop_post.sv
rtl/core/orientation_order_parameters.sv
dv/orientation_order_parameters_tb.sv
